@@ rtl/core/tdps_pkg.sv @@
// tdps_pkg: shared types and constants for the timer prescaler/reload search.
// Holds the controller/datapath command and status structs and field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdps_pkg;

	// Field widths fixed by the interface
	localparam int SEL_W   = 8;
	localparam int REQ_W   = 40;
	localparam int FIELD_W = 16;
	localparam int BCLK_W  = 29;
	localparam int CLK_W   = BCLK_W + 1;     // timer clock, bus clock possibly doubled
	localparam int NUM_W   = CLK_W + 7;      // 128 * timer clock
	localparam int RHS_W   = CLK_W + 14;     // 12800 * timer clock
	localparam int MCNT_W  = $clog2(REQ_W);

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_BUS_CLOCK_HZ       = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUS_DIVIDER_ACTIVE = 1'd1;

	localparam logic [BCLK_W-1:0] BUS_CLOCK_RESET = 29'd84000000;

	// Only timer 1 is supported
	localparam logic [SEL_W-1:0] TIMER_ONE = 8'd1;

	typedef struct packed {
		logic load;         // latch request, set up search
		logic search_step;  // one search iteration
		logic mul_init;     // set up margin product
		logic mul_step;     // one shift-add of the margin product
		logic scale;        // apply margin constants
		logic emit;         // register the result
	} tdps_cmd_t;

	typedef struct packed {
		logic search_done;  // current search step is the last one
		logic mul_done;     // current multiply step is the last one
	} tdps_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/timer_divider_pair_search.sv @@
// timer_divider_pair_search: top level of the timer prescaler/reload search.
// Instantiates tdps_ctrl (sequencer) and tdps_dp (datapath).
// Depends on tdps_pkg, tdps_ctrl, tdps_dp.
`timescale 1ns / 1ps
`default_nettype none

// A request (timer_select, target_freq) is taken when start is high and busy
// is low. The block then searches every prescaler p from 2^COUNTER_BITS-1
// down to 1 for the smallest reload r with clk/((r+1)(p+1)) at or below
// target_freq/128, keeps the highest such frequency (smaller p on a tie), and
// checks it against the 99% margin. The search runs one add/compare step per
// cycle: each cycle either moves to the next prescaler or bumps the reload,
// with the products k*d*req, k*req, d*req and k*d kept up to date by adds and
// subtracts. The search ends early once the reload would run past the top,
// and an unsupported timer ends it as soon as it starts. Then come a setup
// step, the shift-add margin product, a scaling step and a step to register
// the result; done is high in the cycle after that. The result appears on
// prescale_value, reload_value and status, with done high for exactly one
// cycle; there is no back-pressure, so the receiver must take it in that
// cycle. busy drops in that same cycle, so the next request may be issued
// while done is high. status 1 means unsupported timer, no usable pair, or
// below margin; the value ports are then 0. Configuration writes (cfg_valid,
// always ready) are expected only while busy is low.
module timer_divider_pair_search #(
	parameter int COUNTER_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// request
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [tdps_pkg::SEL_W-1:0]     timer_select,
	input  wire logic [tdps_pkg::REQ_W-1:0]     target_freq,
	// result
	output logic                                done,
	output logic [tdps_pkg::FIELD_W-1:0]        prescale_value,
	output logic [tdps_pkg::FIELD_W-1:0]        reload_value,
	output logic                                status,
	// configuration
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tdps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tdps_pkg::BCLK_W-1:0]    cfg_data
);
	import tdps_pkg::*;

	tdps_cmd_t  cmd;
	tdps_stat_t stat;

	// config regs are plain registers: always ready
	assign cfg_ready = 1'b1;

	tdps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	tdps_dp #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.timer_select   (timer_select),
		.target_freq    (target_freq),
		.cmd            (cmd),
		.stat           (stat),
		.prescale_value (prescale_value),
		.reload_value   (reload_value),
		.status         (status)
	);

endmodule

`default_nettype wire

@@ rtl/core/tdps_ctrl.sv @@
// tdps_ctrl: sequencing state machine for the prescaler/reload search.
// Drives tdps_cmd_t to the datapath, reads tdps_stat_t back.
// Depends on tdps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdps_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output logic                   done,
	output tdps_pkg::tdps_cmd_t    cmd,
	input  wire tdps_pkg::tdps_stat_t stat
);
	import tdps_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_MUL_INIT,
		S_MUL,
		S_SCALE,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (stat.search_done) begin
					state_d = S_MUL_INIT;
				end
			end
			S_MUL_INIT: begin
				state_d = S_MUL;
			end
			S_MUL: begin
				if (stat.mul_done) begin
					state_d = S_SCALE;
				end
			end
			S_SCALE: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_EMIT);
		end
	end

	always_comb begin
		cmd             = '0;
		cmd.load        = (state_q == S_IDLE) && start;
		cmd.search_step = (state_q == S_SEARCH);
		cmd.mul_init    = (state_q == S_MUL_INIT);
		cmd.mul_step    = (state_q == S_MUL);
		cmd.scale       = (state_q == S_SCALE);
		cmd.emit        = (state_q == S_EMIT);
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

`ifndef NO_ASSERTIONS
	a_done_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_EMIT))
		else $error("result strobe without emit");

	a_load_starts_search: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_SEARCH))
		else $error("accepted request did not start a search");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.search_step, cmd.mul_init, cmd.mul_step, cmd.scale,
			cmd.emit}))
		else $error("more than one datapath command");

	a_mul_to_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) && stat.mul_done |=> (state_q == S_SCALE))
		else $error("multiply end not followed by scale");
`endif

endmodule

`default_nettype wire

@@ rtl/core/tdps_dp.sv @@
// tdps_dp: datapath for the prescaler/reload search: config registers,
// incremental search over divisor/reload, shift-add margin product, result regs.
// Depends on tdps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdps_dp #(
	parameter int COUNTER_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tdps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tdps_pkg::BCLK_W-1:0]    cfg_data,
	input  wire logic [tdps_pkg::SEL_W-1:0]     timer_select,
	input  wire logic [tdps_pkg::REQ_W-1:0]     target_freq,
	input  wire tdps_pkg::tdps_cmd_t            cmd,
	output tdps_pkg::tdps_stat_t                stat,
	output logic [tdps_pkg::FIELD_W-1:0]        prescale_value,
	output logic [tdps_pkg::FIELD_W-1:0]        reload_value,
	output logic                                status
);
	import tdps_pkg::*;

	localparam int CB = COUNTER_BITS;
	localparam int DW = CB + 1;          // divisor d = p + 1, and k
	localparam int PW = CB + REQ_W + 2;  // k*d*req and friends
	localparam int MW = 2 * CB + 1;      // m = k*d
	localparam int AW = MW + REQ_W;      // m * req
	localparam int LW = AW + 7;          // 99 * m * req

	// config
	logic [BCLK_W-1:0] bus_clk_q;
	logic              bus_div_q;

	// search state
	logic [DW-1:0]     d_q;
	logic [DW-1:0]     k_q;
	logic [PW-1:0]     prod_q;   // k*d*req
	logic [PW-1:0]     kr_q;     // k*req
	logic [PW-1:0]     dr_q;     // d*req
	logic [MW-1:0]     m_q;      // k*d
	logic [NUM_W-1:0]  num_q;
	logic [CLK_W-1:0]  clk_hz_q;
	logic [REQ_W-1:0]  req_q;
	logic              sel_ok_q;
	logic              found_q;
	logic [MW-1:0]     best_m_q;
	logic [CB-1:0]     best_p_q;
	logic [CB-1:0]     best_r_q;

	// margin product
	logic [AW-1:0]     acc_q;
	logic [AW-1:0]     mcand_q;
	logic [REQ_W-1:0]  mplier_q;
	logic [MCNT_W-1:0] mcnt_q;
	logic [LW-1:0]     lhs_q;
	logic [RHS_W-1:0]  rhs_q;

	// results
	logic [FIELD_W-1:0] prescale_q;
	logic [FIELD_W-1:0] reload_q;
	logic               status_q;

	logic [CLK_W-1:0]   clk_hz;
	logic               exhausted;
	logic               reached;
	logic               last_d;
	logic               take;
	logic [DW-1:0]      d_m1;
	logic [DW-1:0]      k_m1;
	logic               fail;
	logic [CB+FIELD_W-1:0] p_ext;
	logic [CB+FIELD_W-1:0] r_ext;

	assign clk_hz    = bus_div_q ? {bus_clk_q, 1'b0} : {1'b0, bus_clk_q};
	assign exhausted = k_q[CB];                      // reload would pass the top
	assign reached   = (prod_q >= PW'(num_q));       // clk/(k*d) at or below target_freq/128
	assign last_d    = (d_q == DW'(2));
	assign take      = reached && !exhausted && (!found_q || (m_q <= best_m_q));
	assign d_m1      = d_q - DW'(1);
	assign k_m1      = k_q - DW'(1);

	always_comb begin
		stat             = '0;
		stat.search_done = !sel_ok_q || exhausted || (reached && last_d);
		stat.mul_done    = (mcnt_q == MCNT_W'(REQ_W - 1));
	end

	// config registers and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_clk_q <= BUS_CLOCK_RESET;
			bus_div_q <= 1'b0;
			found_q   <= 1'b0;
			sel_ok_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BUS_CLOCK_HZ:       bus_clk_q <= cfg_data;
					CFG_BUS_DIVIDER_ACTIVE: bus_div_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				found_q  <= 1'b0;
				sel_ok_q <= (timer_select == TIMER_ONE);
			end else if (cmd.search_step && take) begin
				found_q <= 1'b1;
			end
		end
	end

	// search datapath: d walks down, k walks up, products kept by add/subtract
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d_q      <= {1'b1, {CB{1'b0}}};
			k_q      <= DW'(1);
			prod_q   <= PW'({target_freq, {CB{1'b0}}});
			dr_q     <= PW'({target_freq, {CB{1'b0}}});
			kr_q     <= PW'(target_freq);
			m_q      <= MW'({1'b1, {CB{1'b0}}});
			req_q    <= target_freq;
			clk_hz_q <= clk_hz;
			num_q    <= {clk_hz, 7'b0};
		end else if (cmd.search_step && !exhausted) begin
			if (reached) begin
				d_q    <= d_m1;
				prod_q <= prod_q - kr_q;
				dr_q   <= dr_q - PW'(req_q);
				m_q    <= m_q - MW'(k_q);
			end else begin
				k_q    <= k_q + DW'(1);
				prod_q <= prod_q + dr_q;
				kr_q   <= kr_q + PW'(req_q);
				m_q    <= m_q + MW'(d_q);
			end
		end
		if (cmd.search_step && take) begin
			best_m_q <= m_q;
			best_p_q <= d_m1[CB-1:0];
			best_r_q <= k_m1[CB-1:0];
		end
	end

	// margin: 99 * m * req against 12800 * clk, m*req by shift-add
	always_ff @(posedge clk) begin
		if (cmd.mul_init) begin
			acc_q    <= '0;
			mcand_q  <= AW'(best_m_q);
			mplier_q <= req_q;
			mcnt_q   <= '0;
		end else if (cmd.mul_step) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[AW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[REQ_W-1:1]};
			mcnt_q   <= mcnt_q + MCNT_W'(1);
		end
		if (cmd.scale) begin
			lhs_q <= (LW'(acc_q) << 6) + (LW'(acc_q) << 5) + (LW'(acc_q) << 1) + LW'(acc_q);
			rhs_q <= (RHS_W'(clk_hz_q) << 13) + (RHS_W'(clk_hz_q) << 12)
				+ (RHS_W'(clk_hz_q) << 9);
		end
	end

	assign fail  = !sel_ok_q || !found_q || (lhs_q > LW'(rhs_q));
	assign p_ext = {{FIELD_W{1'b0}}, best_p_q};
	assign r_ext = {{FIELD_W{1'b0}}, best_r_q};

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			prescale_q <= fail ? '0 : p_ext[FIELD_W-1:0];
			reload_q   <= fail ? '0 : r_ext[FIELD_W-1:0];
			status_q   <= fail;
		end
	end

	assign prescale_value = prescale_q;
	assign reload_value   = reload_q;
	assign status         = status_q;

endmodule

`default_nettype wire
